// ===== design/cism_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Case-insensitive substring match package
// Shared types, constants and the letter case folding function.
// ----------------------------------------------------------------------------
package cism_pkg;

   localparam int PATTERN_MAX_DEFAULT = 128;
   localparam int LINE_MAX_DEFAULT    = 1024;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 7;
   localparam int LEN_W   = 8;
   localparam int MATCH_W = 10;

   localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'h41;
   localparam logic [BYTE_W-1:0] UPPER_LAST  = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;

   localparam logic OP_PATTERN_WRITE = 1'b0;
   localparam logic OP_TEXT_BYTE     = 1'b1;

   typedef struct packed {
      logic              adv;
      logic              clr;
      logic [BYTE_W-1:0] text;
      logic [BYTE_W-1:0] wdata;
   } cell_ctrl_type;

   typedef struct packed {
      logic               found;
      logic [MATCH_W-1:0] match_start;
      logic               line_done;
      logic               no_match;
   } rsp_item_type;

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      r = c;
      if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/case_insensitive_substring_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Case-insensitive substring match
// Reports the first case-insensitive occurrence of a stored pattern in each
// text line, one result per text byte.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries pattern writes (no result) and text bytes
// (one result each). The pattern length is written through csr_wr_en and
// csr_wr_data while the block is idle; the user must keep to this, as the
// block does not enforce it. A row of PATTERN_MAX match cells compares
// every text byte against all pattern bytes in the same cycle and passes
// its partial-match bits along the row. Throughput is one item per cycle
// while req_stall is low. Results leave through an output register, and
// when the receiver stalls one more item is held in a skid stage; after
// that req_stall rises until the receiver takes the waiting result. Reset
// clears the partial matches, the line offset, the found flag, the pattern
// length and the result buffer; pattern bytes are undefined until written.
// ----------------------------------------------------------------------------
module case_insensitive_substring_match #(
   parameter int PATTERN_MAX = cism_pkg::PATTERN_MAX_DEFAULT,
   parameter int LINE_MAX    = cism_pkg::LINE_MAX_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_operation,
   input  wire logic [cism_pkg::BYTE_W-1:0]  req_data_byte,
   input  wire logic [cism_pkg::INDEX_W-1:0] req_pattern_index,
   input  wire logic                         req_line_end,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_found,
   output logic [cism_pkg::MATCH_W-1:0]      rsp_match_start,
   output logic                              rsp_line_done,
   output logic                              rsp_no_match,
   input  wire logic                         csr_wr_en,
   input  wire logic [cism_pkg::LEN_W-1:0]   csr_wr_data
);
   import cism_pkg::*;

   localparam int OFS_W = $clog2(LINE_MAX);
   localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
   localparam int DW = (OFS_W > PLEN_W) ? OFS_W : PLEN_W;

   logic [LEN_W-1:0]  pattern_length_ff;
   logic [PLEN_W-1:0] len_eff;
   logic [OFS_W-1:0]  offset_ff, offset_in;
   logic              found_ff, found_in;
   logic              accept, text_acc, pat_wr, hit, found_now;
   logic [DW-1:0]     cur_d, lm1_d, start_d;
   cell_ctrl_type     ctrl;
   logic [PATTERN_MAX-1:0] wr_sel, len_sel, match_new, match_bits;
   rsp_item_type      push_item, rsp_item;

   assign accept   = req_valid && !req_stall;
   assign text_acc = accept && (req_operation == OP_TEXT_BYTE);
   assign pat_wr   = accept && (req_operation == OP_PATTERN_WRITE);

   assign len_eff = (32'(pattern_length_ff) > PATTERN_MAX) ? PLEN_W'(PATTERN_MAX)
                                                           : PLEN_W'(pattern_length_ff);

   always_comb begin
      ctrl.adv   = text_acc;
      ctrl.clr   = req_line_end;
      ctrl.text  = fold_case(req_data_byte);
      ctrl.wdata = fold_case(req_data_byte);
   end

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      assign wr_sel[k]  = pat_wr && (32'(req_pattern_index) == k);
      assign len_sel[k] = (32'(len_eff) == k + 1);
      cism_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .wr_en        (wr_sel[k]),
         .prev_bit     ((k == 0) ? 1'b1 : match_bits[(k == 0) ? 0 : k - 1]),
         .match_new    (match_new[k]),
         .match_bit_ff (match_bits[k])
      );
   end

   always_comb begin
      hit       = (len_eff == '0) || (|(match_new & len_sel));
      found_now = hit && !found_ff;
      cur_d     = DW'(offset_ff);
      lm1_d     = DW'(len_eff) - DW'(1);
      if (len_eff == '0) begin
         start_d = cur_d;
      end else if (cur_d >= lm1_d) begin
         start_d = cur_d - lm1_d;
      end else begin
         start_d = '0;
      end

      push_item.found       = found_now;
      push_item.match_start = found_now ? MATCH_W'(start_d) : '0;
      push_item.line_done   = req_line_end;
      push_item.no_match    = req_line_end && !(found_ff || found_now);

      offset_in = offset_ff;
      found_in  = found_ff;
      if (text_acc) begin
         if (req_line_end) begin
            offset_in = '0;
            found_in  = 1'b0;
         end else begin
            found_in = found_ff || found_now;
            if (offset_ff < OFS_W'(LINE_MAX - 1)) begin
               offset_in = offset_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         offset_ff         <= '0;
         found_ff          <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pattern_length_ff <= csr_wr_data;
         end
         offset_ff <= offset_in;
         found_ff  <= found_in;
      end
   end

   cism_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (text_acc),
      .push_item (push_item),
      .rsp_stall (rsp_stall),
      .in_stall  (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_found       = rsp_item.found;
   assign rsp_match_start = rsp_item.match_start;
   assign rsp_line_done   = rsp_item.line_done;
   assign rsp_no_match    = rsp_item.no_match;

endmodule
`default_nettype wire

// ===== design/cism_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Match cell
// Holds one folded pattern byte and one partial-match bit. The bit is set
// when the neighbor's bit was set and the text byte equals the pattern byte.
// ----------------------------------------------------------------------------
module cism_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cism_pkg::cell_ctrl_type ctrl,
   input  wire logic                  wr_en,
   input  wire logic                  prev_bit,
   output logic                       match_new,
   output logic                       match_bit_ff
);
   import cism_pkg::*;

   logic [BYTE_W-1:0] pat_ff;
   logic              match_bit_in;

   always_comb begin
      match_new    = prev_bit && (pat_ff == ctrl.text);
      match_bit_in = match_bit_ff;
      if (ctrl.adv) begin
         match_bit_in = ctrl.clr ? 1'b0 : match_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_bit_ff <= 1'b0;
      end else begin
         match_bit_ff <= match_bit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_ff <= ctrl.wdata;
      end
   end

endmodule
`default_nettype wire

// ===== design/cism_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Result buffer
// Output register with a skid stage, so a new item is taken while a result
// waits for the receiver.
// ----------------------------------------------------------------------------
module cism_out (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire cism_pkg::rsp_item_type push_item,
   input  wire logic                   rsp_stall,
   output logic                        in_stall,
   output logic                        rsp_valid,
   output cism_pkg::rsp_item_type      rsp_item
);
   import cism_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         take;

   always_comb begin
      take          = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (take || !out_valid_ff) begin
            out_item_in   = skid_item_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (take || !out_valid_ff) begin
            out_item_in  = push_item;
            out_valid_in = 1'b1;
         end else begin
            skid_item_in  = push_item;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign in_stall  = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule
`default_nettype wire

// ===== design/cism_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Case-insensitive substring match checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cism_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic                         rsp_found,
   input wire logic [cism_pkg::MATCH_W-1:0] rsp_match_start,
   input wire logic                         rsp_line_done,
   input wire logic                         rsp_no_match
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) &&
         $stable(rsp_match_start) && $stable(rsp_line_done) && $stable(rsp_no_match))
      else $error("stalled result item changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_found_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> !rsp_no_match)
      else $error("found and no_match in one item");

   a_nomatch_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_match |-> rsp_line_done)
      else $error("no_match away from line end");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_start == '0)
      else $error("match_start set without found");

endmodule

bind case_insensitive_substring_match cism_checker u_cism_checker (.*);
`default_nettype wire
